### src/tsrc_pkg.sv
// tsrc_pkg: shared types and constants of the terrain shadow ray caster
// no dependencies
`timescale 1ns / 1ps

package tsrc_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_ROWS = 3'd0,
		REG_GRID_COLS = 3'd1,
		REG_NODATA    = 3'd2,
		REG_STEP_ROW  = 3'd3,
		REG_STEP_COL  = 3'd4,
		REG_RISE      = 3'd5,
		REG_SUN_UP    = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLASS_SHADOW = 2'd0,
		CLASS_LIT    = 2'd1,
		CLASS_NODATA = 2'd2
	} pixel_class_t;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

endpackage

### src/terrain_shadow_ray_caster_core.sv
// terrain_shadow_ray_caster_core: elevation grid store and ray marching shadow classifier
// depends on tsrc_pkg
`timescale 1ns / 1ps

// One request at a time. A load request writes one cell in the cycle it is accepted.
// A query request reads its own cell and then marches a ray toward the sun. Each step
// reads the four corners of the bilinear patch through the single read port of the
// elevation memory. Then three interpolation passes share one multiplier, and a final
// state does the compare against the threshold. The number of steps marched, k, is at
// most 4 * (rows + cols). The memory read port and the shared multiplier set the time
// a query takes. A finished result sits in an output register, and the next request is
// taken while it waits. The memory has no reset and no clearing pass, so cells read
// before they are written are undefined.
module terrain_shadow_ray_caster_core
	import tsrc_pkg::*;
#(
	parameter int MAX_ROWS      = 256,
	parameter int MAX_COLS      = 256,
	parameter int POS_FRAC_BITS = 15,
	parameter int ELEV_WIDTH    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  row_index,
	input  logic [7:0]  col_index,
	input  logic signed [23:0] elevation,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  pixel_class,
	output logic [7:0]  out_row,
	output logic [7:0]  out_col
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int AW = RW + CW;
	localparam int EW = ELEV_WIDTH;
	localparam int F  = POS_FRAC_BITS;
	// position: integer part wide enough for a few grid lengths of overshoot, plus sign
	localparam int PW = F + ((RW > CW) ? RW : CW) + 3;
	// threshold can grow by under 2^24 per step over up to 2^11 steps
	localparam int TW = 48;
	// step counter holds 4 * (rows + cols)
	localparam int KW = ((RW > CW) ? RW : CW) + 4;
	localparam int DW = EW + 2;       // difference of two elevations
	localparam int MW = DW + F + 2;   // product plus rounding

	// configuration
	logic [8:0]          grid_rows_q, grid_cols_q;
	logic signed [23:0]  nodata_q;
	logic signed [15:0]  step_row_q, step_col_q;
	logic [23:0]         rise_q;
	logic                sun_up_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= 9'd256;
			grid_cols_q <= 9'd256;
			nodata_q    <= 24'sh800000;
			step_row_q  <= -16'sd16384;
			step_col_q  <= 16'sd0;
			rise_q      <= 24'd0;
			sun_up_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_ROWS: grid_rows_q <= cfg_data[8:0];
				REG_GRID_COLS: grid_cols_q <= cfg_data[8:0];
				REG_NODATA:    nodata_q    <= cfg_data[23:0];
				REG_STEP_ROW:  step_row_q  <= cfg_data[15:0];
				REG_STEP_COL:  step_col_q  <= cfg_data[15:0];
				REG_RISE:      rise_q      <= cfg_data[23:0];
				REG_SUN_UP:    sun_up_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective grid size: 0 counts as 1, saturate at the store size
	logic [12:0] rows_eff, cols_eff;
	always_comb begin
		rows_eff = 13'(grid_rows_q);
		if (grid_rows_q == 9'd0) rows_eff = 13'd1;
		else if (13'(grid_rows_q) > 13'(MAX_ROWS)) rows_eff = 13'(MAX_ROWS);
		cols_eff = 13'(grid_cols_q);
		if (grid_cols_q == 9'd0) cols_eff = 13'd1;
		else if (13'(grid_cols_q) > 13'(MAX_COLS)) cols_eff = 13'(MAX_COLS);
	end

	logic signed [EW-1:0] nod_e;
	assign nod_e = EW'(nodata_q);

	// elevation memory, one write and one registered read port
	logic [EW-1:0] mem [0:(1<<AW)-1];
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata <= mem[mem_raddr];
	end

	typedef enum logic [3:0] {
		S_IDLE, S_HOME, S_STEP, S_RD01, S_RD10, S_RD11, S_GET11,
		S_LTOP, S_LBOT, S_LH, S_CMP, S_DONE
	} state_t;

	state_t state_q;
	logic [7:0]  qrow_q, qcol_q;
	logic signed [PW-1:0] pr_q, pc_q;
	logic signed [TW-1:0] thr_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] a01_q, a10_q, a11_q;
	logic [F-1:0]  fr_q, fc_q;
	logic signed [EW-1:0] v00_q, v01_q, v10_q;
	logic signed [EW+1:0] top_q, bot_q;
	logic nodhit_q;
	logic [1:0] res_class_q;
	logic [1:0] out_class_q;
	logic       res_pend_q;

	// shared interpolation: a + round((b-a)*f / 2^F), floor of signed
	logic signed [EW+1:0] la, lb, lres;
	logic [F-1:0]  lf;
	logic signed [DW-1:0] ldiff;
	logic signed [MW-1:0] lprod;
	always_comb begin
		ldiff = DW'(lb) - DW'(la);
		lprod = MW'(ldiff) * MW'($signed({1'b0, lf})) + MW'(1 << (F-1));
		lres  = la + (EW+2)'(lprod >>> F);
	end

	// next position and bounds
	logic signed [PW-1:0] npr, npc;
	logic [RW-1:0] r0, r1;
	logic [CW-1:0] c0, c1;
	logic out_of_grid;
	always_comb begin
		npr = pr_q + PW'(step_row_q);
		npc = pc_q + PW'(step_col_q);
		out_of_grid = npr < 0 || npc < 0 ||
			(npr >>> F) >= PW'(rows_eff) || (npc >>> F) >= PW'(cols_eff);
		r0 = RW'(npr >>> F);
		c0 = CW'(npc >>> F);
		r1 = ((PW'(r0) + 1) < PW'(rows_eff)) ? RW'(r0 + 1'b1) : r0;
		c1 = ((PW'(c0) + 1) < PW'(cols_eff)) ? CW'(c0 + 1'b1) : c0;
	end

	logic [KW-1:0] k_lim;
	assign k_lim = KW'({rows_eff, 2'b00}) + KW'({cols_eff, 2'b00});

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = res_pend_q;

	always_comb begin
		mem_we    = in_valid && in_ready && kind == KIND_LOAD &&
			32'(row_index) < MAX_ROWS && 32'(col_index) < MAX_COLS;
		mem_waddr = {RW'(row_index), CW'(col_index)};
		mem_wdata = EW'(elevation);
		mem_raddr = {RW'(qrow_q), CW'(qcol_q)};
		la = top_q; lb = bot_q; lf = fr_q;
		unique case (state_q)
			S_IDLE:  mem_raddr = {RW'(row_index), CW'(col_index)};
			S_STEP:  mem_raddr = {r0, c0};
			S_RD01:  mem_raddr = a01_q;
			S_RD10:  mem_raddr = a10_q;
			S_RD11, S_GET11, S_LTOP: mem_raddr = a11_q;
			default: ;
		endcase
		unique case (state_q)
			S_LTOP: begin la = (EW+2)'(v00_q); lb = (EW+2)'(v01_q); lf = fc_q; end
			S_LBOT: begin la = (EW+2)'(v10_q); lb = (EW+2)'($signed(mem_rdata)); lf = fc_q; end
			default: ;
		endcase
	end

	// the query cell read is registered, so hold the request coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_pend_q  <= 1'b0;
			res_class_q <= CLASS_LIT;
			out_class_q <= CLASS_LIT;
			k_q         <= '0;
			nodhit_q    <= 1'b0;
		end else begin
			if (res_pend_q && out_ready && state_q != S_DONE) res_pend_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready && kind == KIND_QUERY) begin
					qrow_q  <= row_index;
					qcol_q  <= col_index;
					state_q <= S_HOME;
				end
				S_HOME: begin
					pr_q  <= PW'({qrow_q, F'(0)});
					pc_q  <= PW'({qcol_q, F'(0)});
					thr_q <= TW'($signed(mem_rdata));
					k_q   <= '0;
					if (13'(qrow_q) >= rows_eff || 13'(qcol_q) >= cols_eff ||
						$signed(mem_rdata) == nod_e) begin
						res_class_q <= CLASS_NODATA;
						state_q     <= S_DONE;
					end else if (!sun_up_q) begin
						res_class_q <= CLASS_SHADOW;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (k_q == k_lim) begin
						res_class_q <= CLASS_LIT;
						state_q     <= S_DONE;
					end else begin
						k_q   <= k_q + 1'b1;
						pr_q  <= npr;
						pc_q  <= npc;
						thr_q <= thr_q + TW'(rise_q);
						fr_q  <= F'(npr);
						fc_q  <= F'(npc);
						a01_q <= {r0, c1};
						a10_q <= {r1, c0};
						a11_q <= {r1, c1};
						if (out_of_grid) begin
							res_class_q <= CLASS_LIT;
							state_q     <= S_DONE;
						end else begin
							state_q <= S_RD01;
						end
					end
				end
				S_RD01: begin
					v00_q    <= mem_rdata;
					nodhit_q <= $signed(mem_rdata) == nod_e;
					state_q  <= S_RD10;
				end
				S_RD10: begin
					v01_q    <= mem_rdata;
					nodhit_q <= nodhit_q || $signed(mem_rdata) == nod_e;
					state_q  <= S_RD11;
				end
				S_RD11: begin
					v10_q    <= mem_rdata;
					nodhit_q <= nodhit_q || $signed(mem_rdata) == nod_e;
					state_q  <= S_GET11;
				end
				S_GET11: begin
					if (nodhit_q || $signed(mem_rdata) == nod_e) begin
						res_class_q <= CLASS_LIT;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_LTOP;
					end
				end
				S_LTOP: begin
					top_q   <= lres;
					state_q <= S_LBOT;
				end
				S_LBOT: begin
					// mem_rdata still holds the far corner
					bot_q   <= lres;
					state_q <= S_LH;
				end
				S_LH: begin
					top_q   <= lres;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (TW'(top_q) > thr_q) begin
						res_class_q <= CLASS_SHADOW;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_DONE: if (!res_pend_q || out_ready) begin
					res_pend_q  <= 1'b1;
					out_class_q <= res_class_q;
					out_row     <= qrow_q;
					out_col     <= qcol_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pixel_class = out_class_q;

	// a result only appears at the end of a query
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_DONE)
		else $error("result without finished query");
	// no request accepted while marching
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("request taken while busy");
	// step count never passes the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= k_lim || state_q == S_IDLE || state_q == S_HOME || state_q == S_DONE)
		else $error("step count overrun");

endmodule
